// File: hw/rtl/lkvc_pkg.sv
// Shared widths, constants and transaction types of the LRU key-value cache.
package lkvc_pkg;

	localparam int KEY_BITS     = 16;
	localparam int VALUE_BITS   = 32;
	localparam int CAP_BITS     = 5;
	localparam int ENTRIES_DEF  = 16;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
	} out_item_t;

	typedef struct packed {
		logic                step;
		logic                put_miss;
		logic [KEY_BITS-1:0] key;
	} cell_ctl_t;

endpackage

// File: hw/rtl/lkvc_cell.sv
// One entry of the recency-ordered store: compare, hit chain and shift from its neighbor.
module lkvc_cell (
	input  logic                           clk,
	input  lkvc_pkg::cell_ctl_t            ctl,
	input  logic                           in_range,
	input  logic                           in_ins,
	input  logic [lkvc_pkg::KEY_BITS-1:0]  prev_key,
	input  logic [lkvc_pkg::VALUE_BITS-1:0] prev_value,
	input  logic                           match_hi_in,
	input  logic [lkvc_pkg::VALUE_BITS-1:0] rd_in,
	output logic [lkvc_pkg::KEY_BITS-1:0]  key,
	output logic [lkvc_pkg::VALUE_BITS-1:0] value,
	output logic                           match_hi_out,
	output logic [lkvc_pkg::VALUE_BITS-1:0] rd_out
);
	import lkvc_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  match;
	logic                  shift;

	assign match        = in_range && (key_q == ctl.key);
	assign match_hi_out = match_hi_in | match;
	assign rd_out       = rd_in | (match ? value_q : '0);
	assign shift        = match_hi_out | (ctl.put_miss & in_ins);

	always_ff @(posedge clk) begin
		if (ctl.step && shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache built as a chain of entry cells.
// The cache takes one get or put transaction per clock cycle while the output is not
// stalled and returns its result in the output register on the next cycle; the key
// compare, hit and read-data chains run through all ENTRIES cells. Entries are kept in
// recency order, most recent in cell 0, and every hit and every put shifts the cells in
// front of the hit or insert position by one, while a get that misses leaves them as they
// are. Writing capacity empties the store at once, with no clearing pass; capacity zero
// acts as one and values above ENTRIES act as ENTRIES.
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lkvc_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lkvc_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_data
);
	import lkvc_pkg::*;

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	logic [CAP_BITS-1:0]   capacity_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         eff_cap;
	logic [CW-1:0]         occ_ext;
	logic [CW-1:0]         ins_pos;
	logic                  step;
	logic                  hit;
	logic [VALUE_BITS-1:0] rd;
	logic [VALUE_BITS-1:0] front_value;
	cell_ctl_t             ctl;

	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [VALUE_BITS-1:0] cell_value [ENTRIES];
	logic                  match_hi   [ENTRIES+1];
	logic [VALUE_BITS-1:0] rd_chain   [ENTRIES+1];

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;

	assign cap_ext = CW'(capacity_q);
	assign occ_ext = CW'(occ_q);

	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		if (occ_ext >= eff_cap) begin
			ins_pos = eff_cap - CW'(1);
		end else begin
			ins_pos = occ_ext;
		end
	end

	assign hit         = match_hi[0];
	assign rd          = rd_chain[0];
	assign front_value = (in_data.kind == KIND_PUT) ? in_data.value : rd;

	assign ctl.step     = step;
	assign ctl.put_miss = (in_data.kind == KIND_PUT) && !hit;
	assign ctl.key      = in_data.key;

	assign match_hi[ENTRIES] = 1'b0;
	assign rd_chain[ENTRIES] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]   prev_key;
		logic [VALUE_BITS-1:0] prev_value;

		if (i == 0) begin : g_front
			assign prev_key   = in_data.key;
			assign prev_value = front_value;
		end else begin : g_rest
			assign prev_key   = cell_key[i-1];
			assign prev_value = cell_value[i-1];
		end

		lkvc_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.in_range     (CW'(i) < occ_ext),
			.in_ins       (CW'(i) <= ins_pos),
			.prev_key     (prev_key),
			.prev_value   (prev_value),
			.match_hi_in  (match_hi[i+1]),
			.rd_in        (rd_chain[i+1]),
			.key          (cell_key[i]),
			.value        (cell_value[i]),
			.match_hi_out (match_hi[i]),
			.rd_out       (rd_chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			occ_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
			occ_q      <= '0;
		end else if (step && ctl.put_miss) begin
			occ_q <= OCC_W'(ins_pos + CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.hit        <= hit;
			out_q.read_value <= (in_data.kind == KIND_GET) ? rd : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hw/rtl/lkvc_checker.sv
// Port-level checker of the LRU key-value cache and its bind to the top level.
module lkvc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input lkvc_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input lkvc_pkg::out_item_t out_data
);
	import lkvc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result transaction dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("Result payload changed while stalled.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("Accepted transaction produced no result.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) && (!out_valid || out_ready) |=> !out_valid)
		else $error("Result appeared without an accepted transaction.");

	a_put_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind == KIND_PUT |=> out_data.read_value == '0)
		else $error("Put transaction returned a nonzero value.");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: tb/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key-value cache with a scoreboard and random stalls.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int ENTRIES = ENTRIES_DEF;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 80;

	class cache_scoreboard;
		logic [KEY_BITS-1:0]   keys [ENTRIES];
		logic [VALUE_BITS-1:0] vals [ENTRIES];
		int                    fill;
		logic [CAP_BITS-1:0]   cap_reg;
		out_item_t             expected_responses [$];
		int                    errors;
		int                    accesses;
		int                    hits;
		int                    evictions;

		function new();
			fill = 0;
			cap_reg = CAP_RESET;
			errors = 0;
			accesses = 0;
			hits = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_BITS-1:0] c);
			cap_reg = c;
			fill = 0;
		endfunction

		function void promote(int pos, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
			int i;
			for (i = pos; i > 0; i--) begin
				keys[i] = keys[i-1];
				vals[i] = vals[i-1];
			end
			keys[0] = k;
			vals[0] = v;
		endfunction

		function void note_access(in_item_t item);
			int        eff;
			int        pos;
			int        i;
			bit        found;
			out_item_t resp;
			eff = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
			if (fill > eff)
				fill = eff;
			found = 1'b0;
			pos = 0;
			for (i = 0; i < fill; i++) begin
				if (!found && keys[i] == item.key) begin
					found = 1'b1;
					pos = i;
				end
			end
			resp.hit = found;
			resp.read_value = '0;
			if (item.kind == KIND_GET) begin
				if (found) begin
					resp.read_value = vals[pos];
					promote(pos, item.key, vals[pos]);
				end
			end else if (found) begin
				promote(pos, item.key, item.value);
			end else begin
				if (fill >= eff) begin
					fill = eff - 1;
					evictions++;
				end
				promote(fill, item.key, item.value);
				fill++;
			end
			accesses++;
			if (found)
				hits++;
			expected_responses.insert(expected_responses.size(), resp);
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			if (expected_responses.size() == 0) begin
				$display("%0t: unexpected response hit=%0b read_value=%h", $time,
					got.hit, got.read_value);
				errors++;
				return;
			end
			want = expected_responses.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit mismatch, expected %0b, actual %0b", $time,
					want.hit, got.hit);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value mismatch, expected %h, actual %h", $time,
					want.read_value, got.read_value);
				errors++;
			end
		endfunction

		function int pending();
			return expected_responses.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data;

	cache_scoreboard board = new();
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	bit              long_hold_req = 1'b0;
	int              cycle_count = 0;
	int              cap_writes = 0;

	lru_key_value_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("lru_key_value_cache_tb: done, errors");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_response(out_data);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic in_item_t make_item(kind_t k, logic [KEY_BITS-1:0] key,
		logic [VALUE_BITS-1:0] value);
		in_item_t it;
		it.kind = k;
		it.key = key;
		it.value = value;
		return it;
	endfunction

	task automatic send_item(input in_item_t item);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		board.note_access(item);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] c);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		board.set_capacity(c);
		cap_writes++;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                  p;
		int                  n;
		int                  eff;
		int                  pool_size;
		int                  phase_cap [PHASES];
		logic [KEY_BITS-1:0] key_pool [$];
		in_item_t            it;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed checks at the reset capacity, then small capacities and eviction.
		send_item(make_item(KIND_GET, 16'h0000, 32'h0));
		send_item(make_item(KIND_PUT, 16'h0000, 32'hFFFF_FFFF));
		send_item(make_item(KIND_GET, 16'h0000, 32'h0));
		send_item(make_item(KIND_PUT, 16'hFFFF, 32'h0000_0000));
		send_item(make_item(KIND_GET, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(make_item(KIND_PUT, 16'h0000, 32'h1234_5678));
		send_item(make_item(KIND_GET, 16'h0000, 32'h0));
		stop_sending();
		write_capacity(5'd2);
		send_item(make_item(KIND_GET, 16'h0000, 32'h0));
		send_item(make_item(KIND_PUT, 16'h0001, 32'hA5A5_0001));
		send_item(make_item(KIND_PUT, 16'h0002, 32'hA5A5_0002));
		send_item(make_item(KIND_PUT, 16'h0003, 32'hA5A5_0003));
		send_item(make_item(KIND_GET, 16'h0001, 32'h0));
		send_item(make_item(KIND_GET, 16'h0002, 32'h0));
		send_item(make_item(KIND_PUT, 16'h0004, 32'hA5A5_0004));
		send_item(make_item(KIND_GET, 16'h0003, 32'h0));
		send_item(make_item(KIND_GET, 16'h0004, 32'h0));
		send_item(make_item(KIND_GET, 16'h0002, 32'h0));
		stop_sending();
		write_capacity(5'd0);
		send_item(make_item(KIND_PUT, 16'h0005, 32'h5555_5555));
		send_item(make_item(KIND_PUT, 16'h0006, 32'hAAAA_AAAA));
		send_item(make_item(KIND_GET, 16'h0005, 32'h0));
		send_item(make_item(KIND_GET, 16'h0006, 32'h0));
		stop_sending();
		write_capacity(5'd0);
		send_item(make_item(KIND_GET, 16'h0006, 32'h0));
		stop_sending();

		phase_cap[0] = 16;
		phase_cap[1] = 1;
		phase_cap[2] = 0;
		phase_cap[3] = 31;
		phase_cap[4] = 2;
		phase_cap[5] = 17;
		phase_cap[6] = 5;
		phase_cap[7] = $urandom_range(1, 16);

		for (p = 0; p < PHASES; p++) begin
			write_capacity(CAP_BITS'(phase_cap[p]));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			eff = (phase_cap[p] == 0) ? 1 : ((phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p]);
			pool_size = eff + $urandom_range(1, 6);
			key_pool.delete();
			for (n = 0; n < pool_size; n++)
				key_pool.insert(key_pool.size(), KEY_BITS'($urandom));
			if (p == 0 || p == 4)
				long_hold_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				it.kind = ($urandom_range(99) < 45) ? KIND_PUT : KIND_GET;
				it.key = ($urandom_range(9) == 0) ? KEY_BITS'($urandom) :
					key_pool[$urandom_range(key_pool.size() - 1)];
				it.value = $urandom;
				send_item(it);
			end
			stop_sending();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("Ran %0d accesses across %0d capacity writes and four stall patterns.",
			board.accesses, cap_writes);
		$display("Saw %0d hits and %0d evicting puts; %0d mismatches.",
			board.hits, board.evictions, board.errors);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("lru_key_value_cache_tb: done, clean");
		end else begin
			$display("lru_key_value_cache_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkvc_checker.sv
tb/lru_key_value_cache_tb.sv
